/* rtl/sme_pkg.sv */
// shared types and constants of the stack machine execution unit
package sme_pkg;

  localparam int WORD_W = 32;
  localparam int OP_W   = 4;
  localparam int ACT_W  = 3;
  localparam int ADDR_W = 16;

  // instruction codes
  typedef enum logic [OP_W-1:0] {
    OP_HALT  = 4'd0,
    OP_PCHAR = 4'd1,
    OP_PINT  = 4'd2,
    OP_JUMP  = 4'd3,
    OP_DUP   = 4'd4,
    OP_SLEEP = 4'd5,
    OP_PUSH  = 4'd6,
    OP_ADD   = 4'd7,
    OP_STORE = 4'd8,
    OP_LOAD  = 4'd9
  } op_t;

  // result action kinds
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 3'd0,
    ACT_PCHAR  = 3'd1,
    ACT_PINT   = 3'd2,
    ACT_SLEEP  = 3'd3,
    ACT_HALTED = 3'd4,
    ACT_BADOP  = 3'd5,
    ACT_ERROR  = 3'd6
  } act_t;

endpackage

/* rtl/sme_dmem.sv */
// data memory with a zeroing pass after reset, one write and one registered read port
module sme_dmem import sme_pkg::*; #(
  parameter int MEM_DEPTH = 1024,
  parameter int MW        = $clog2(MEM_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [MW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [MW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data,
  output logic              busy
);

  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic              clr_active_r;
  logic [MW-1:0]     clr_addr_r;

  // zeroing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + MW'(1);
      if (clr_addr_r == MW'(MEM_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // write port shared by the sweep and stores
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign busy = clr_active_r;

endmodule

/* rtl/stack_machine_execute.sv */
// stack machine execution unit: operand stack in ram, execute stage and result register
//
//  channel  direction  fields                                   handshake
//  in_      input      operation[3:0], immediate[31:0]          in_valid / in_ready
//  out_     output     action[2:0], value[31:0], next_address   out_valid / out_ready
//
// an item is taken one cycle, its stack words are read at the same edge and it executes
// in the next cycle; a new item is taken in that cycle, so most instructions sustain one
// item per cycle while the result register is not stalled; execute then writes the result
// register. load holds execute while it issues the data memory read and then writes the
// loaded word to the stack. after reset a zeroing pass over data memory runs with in_ready
// low. a stalled result register holds the execute stage, which then holds in_ready low.
module stack_machine_execute import sme_pkg::*; #(
  parameter int STACK_DEPTH = 256,
  parameter int MEM_DEPTH   = 1024,
  parameter int CODE_DEPTH  = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [WORD_W-1:0] in_immediate,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ACT_W-1:0]         out_action,
  output logic signed [WORD_W-1:0] out_value,
  output logic [ADDR_W-1:0]        out_next_address
);

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = SW + 1;
  localparam int MW = $clog2(MEM_DEPTH);
  localparam logic [ADDR_W:0]   CODE_LIM  = (ADDR_W+1)'(CODE_DEPTH);
  localparam logic [WORD_W-1:0] CODE_LIMW = WORD_W'(CODE_DEPTH);
  localparam logic [WORD_W-1:0] MEM_LIMW  = WORD_W'(MEM_DEPTH);
  localparam logic [CW-1:0]     STK_LIM   = CW'(STACK_DEPTH);

  // operand stack ram and its read registers
  logic [WORD_W-1:0] stk_mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_a_r, rd_b_r, fwd_d_r;
  logic              fwd_a_r, fwd_b_r;

  // architectural state
  logic [CW-1:0]     n_r, n_nxt;
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic              halted_r, halt_nxt;

  // execute stage
  logic              s2_valid_r;
  logic [OP_W-1:0]   op_r;
  logic [WORD_W-1:0] imm_r;
  logic              ld_phase_r;

  // result register
  logic              out_valid_r;
  act_t              out_act_r;
  logic [WORD_W-1:0] out_val_r;
  logic [ADDR_W-1:0] out_pc_r;

  logic              in_fire, s2_fire, done, ld_issue, bad;
  logic              st_wen, dm_wen, stk_we, dm_busy;
  logic [SW-1:0]     st_waddr, ra, rb;
  logic [WORD_W-1:0] st_wdata, dm_wdata, dm_rdata, opa, opb, res_val;
  logic [MW-1:0]     dm_waddr;
  act_t              res_act;
  logic [CW-1:0]     n_m1, n_m2, cnt_src, cnt_m1, cnt_m2;
  logic [ADDR_W:0]   pc_p1, pc_p2;
  logic [ADDR_W-1:0] pc_inc1, pc_inc2;

  assign s2_fire  = s2_valid_r && done && (!out_valid_r || out_ready);
  assign in_ready = !dm_busy && (!s2_valid_r || s2_fire);
  assign in_fire  = in_valid && in_ready;

  // operands with same-edge write forwarding
  assign opa = fwd_a_r ? fwd_d_r : rd_a_r;
  assign opb = fwd_b_r ? fwd_d_r : rd_b_r;

  assign n_m1 = n_r - CW'(1);
  assign n_m2 = n_r - CW'(2);

  // fetch address advance modulo code depth
  assign pc_p1   = {1'b0, pc_r} + (ADDR_W+1)'(1);
  assign pc_p2   = {1'b0, pc_r} + (ADDR_W+1)'(2);
  assign pc_inc1 = (pc_p1 >= CODE_LIM) ? ADDR_W'(pc_p1 - CODE_LIM) : pc_p1[ADDR_W-1:0];
  assign pc_inc2 = (pc_p2 >= CODE_LIM) ? ADDR_W'(pc_p2 - CODE_LIM) : pc_p2[ADDR_W-1:0];

  // execute one instruction
  always_comb begin
    n_nxt    = n_r;
    pc_nxt   = pc_r;
    halt_nxt = halted_r;
    res_act  = ACT_NONE;
    res_val  = '0;
    st_wen   = 1'b0;
    st_waddr = n_r[SW-1:0];
    st_wdata = opa;
    dm_wen   = 1'b0;
    dm_waddr = opb[MW-1:0];
    dm_wdata = opa;
    ld_issue = 1'b0;
    done     = 1'b1;
    bad      = 1'b0;
    if (halted_r) begin
      res_act = ACT_HALTED;
    end else begin
      unique case (op_t'(op_r))
        OP_HALT: begin
          halt_nxt = 1'b1;
          res_act  = ACT_HALTED;
        end
        OP_PCHAR, OP_PINT, OP_SLEEP: begin
          if (n_r == '0) begin
            bad = 1'b1;
          end else begin
            n_nxt  = n_m1;
            pc_nxt = pc_inc1;
            if (op_t'(op_r) == OP_PCHAR) begin
              res_act = ACT_PCHAR;
              res_val = {{(WORD_W-8){1'b0}}, opa[7:0]};
            end else if (op_t'(op_r) == OP_PINT) begin
              res_act = ACT_PINT;
              res_val = opa;
            end else begin
              res_act = ACT_SLEEP;
              res_val = opa;
            end
          end
        end
        OP_JUMP: begin
          if (imm_r >= CODE_LIMW) begin
            bad = 1'b1;
          end else begin
            pc_nxt = imm_r[ADDR_W-1:0];
          end
        end
        OP_DUP: begin
          if (n_r == '0 || n_r >= STK_LIM) begin
            bad = 1'b1;
          end else begin
            st_wen = 1'b1;
            n_nxt  = n_r + CW'(1);
            pc_nxt = pc_inc1;
          end
        end
        OP_PUSH: begin
          if (n_r >= STK_LIM) begin
            bad = 1'b1;
          end else begin
            st_wen   = 1'b1;
            st_wdata = imm_r;
            n_nxt    = n_r + CW'(1);
            pc_nxt   = pc_inc2;
          end
        end
        OP_ADD: begin
          if (n_r < CW'(2)) begin
            bad = 1'b1;
          end else begin
            st_wen   = 1'b1;
            st_waddr = n_m2[SW-1:0];
            st_wdata = opa + opb;
            n_nxt    = n_m1;
            pc_nxt   = pc_inc1;
          end
        end
        OP_STORE: begin
          if (n_r < CW'(2) || opb >= MEM_LIMW) begin
            bad = 1'b1;
          end else begin
            dm_wen = 1'b1;
            n_nxt  = n_m2;
            pc_nxt = pc_inc1;
          end
        end
        OP_LOAD: begin
          if (n_r == '0 || opa >= MEM_LIMW) begin
            bad = 1'b1;
          end else if (!ld_phase_r) begin
            ld_issue = 1'b1;
            done     = 1'b0;
          end else begin
            st_wen   = 1'b1;
            st_waddr = n_m1[SW-1:0];
            st_wdata = dm_rdata;
            pc_nxt   = pc_inc1;
          end
        end
        default: begin
          halt_nxt = 1'b1;
          res_act  = ACT_BADOP;
        end
      endcase
      if (bad) begin
        n_nxt    = n_r;
        pc_nxt   = pc_r;
        halt_nxt = 1'b1;
        res_act  = ACT_ERROR;
        res_val  = '0;
        st_wen   = 1'b0;
        dm_wen   = 1'b0;
        ld_issue = 1'b0;
        done     = 1'b1;
      end
    end
  end

  assign stk_we = s2_fire && st_wen;

  // read addresses of the incoming item follow the count after this edge
  assign cnt_src = s2_fire ? n_nxt : n_r;
  assign cnt_m1  = cnt_src - CW'(1);
  assign cnt_m2  = cnt_src - CW'(2);
  assign ra      = cnt_m1[SW-1:0];
  assign rb      = cnt_m2[SW-1:0];

  // operand stack ram
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[st_waddr] <= st_wdata;
    end
    if (in_fire) begin
      rd_a_r  <= stk_mem[ra];
      rd_b_r  <= stk_mem[rb];
      fwd_a_r <= stk_we && (st_waddr == ra);
      fwd_b_r <= stk_we && (st_waddr == rb);
      fwd_d_r <= st_wdata;
    end
  end

  // data memory
  sme_dmem #(
    .MEM_DEPTH (MEM_DEPTH),
    .MW        (MW)
  ) u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s2_fire && dm_wen),
    .wr_addr (dm_waddr),
    .wr_data (dm_wdata),
    .rd_en   (s2_valid_r && ld_issue),
    .rd_addr (opa[MW-1:0]),
    .rd_data (dm_rdata),
    .busy    (dm_busy)
  );

  // execute stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      ld_phase_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s2_valid_r <= 1'b1;
      end else if (s2_fire) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_fire) begin
        ld_phase_r <= 1'b0;
      end else if (s2_valid_r && ld_issue) begin
        ld_phase_r <= 1'b1;
      end
    end
  end

  // item payload into execute
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_operation;
      imm_r <= $unsigned(in_immediate);
    end
  end

  // architectural state commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r      <= '0;
      pc_r     <= '0;
      halted_r <= 1'b0;
    end else if (s2_fire) begin
      n_r      <= n_nxt;
      pc_r     <= pc_nxt;
      halted_r <= halt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_act_r <= res_act;
      out_val_r <= res_val;
      out_pc_r  <= pc_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_act_r;
  assign out_value        = $signed(out_val_r);
  assign out_next_address = out_pc_r;

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    dm_busy |-> !in_ready) else $error("item accepted during memory clear");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= STK_LIM) else $error("stack count beyond depth");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r) else $error("halted flag dropped");

  a_load_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ld_phase_r |-> (s2_valid_r && op_t'(op_r) == OP_LOAD))
    else $error("load phase without load in execute");

  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pc_r} < CODE_LIM) else $error("fetch address beyond code depth");
`endif

endmodule
